// ----- hw/rtl/cba_pkg.sv -----
// cba_pkg: shared types and constants of the compacting block allocator
// no dependencies
`default_nettype none
package cba_pkg;
   localparam int unsigned OFF_W   = 24;
   localparam int unsigned CNT_W   = 24;
   localparam int unsigned OWNER_W = 32;
   localparam int unsigned WORDS_W = 22;
   localparam int unsigned MAX_MOVES = 32;

   typedef enum logic [2:0] {
      REQ_ALLOC = 3'd0, REQ_FREE = 3'd1, REQ_FLOAT = 3'd2,
      REQ_LOCK = 3'd3, REQ_FIT = 3'd4, REQ_INIT = 3'd5
   } req_code_type;

   typedef enum logic [1:0] {
      ST_NULL = 2'd0, ST_FREE = 2'd1, ST_LOCKED = 2'd2, ST_FLOAT = 2'd3
   } slot_st_type;

   typedef enum logic [1:0] {
      STS_OK = 2'd0, STS_NOSPACE = 2'd1, STS_NOHANDLE = 2'd2, STS_NOFIT = 2'd3
   } status_type;

   localparam logic [0:0] CSR_POOL = 1'b0;
   localparam logic [0:0] CSR_GAP  = 1'b1;

   typedef enum logic [3:0] {
      FSM_IDLE, FSM_INIT, FSM_WSTART, FSM_WALK, FSM_WMOVE, FSM_FINISH,
      FSM_SPARE, FSM_FIT, FSM_SIMPLE, FSM_RESP
   } fsm_type;

   // controller to datapath command
   typedef struct packed {
      logic       init_step;
      logic       init_start;
      logic       capture;
      logic       walk_start;
      logic       walk_step;
      logic       finish;
      logic       spare_step;
      logic       fit_start;
      logic       fit_step;
      logic       simple;
      logic       load_rsp;
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic init_done;
      logic walk_found;
      logic walk_fail;
      logic walk_move;
      logic need_spare;
      logic spare_found;
      logic spare_done;
      logic fit_done;
   } stat_type;
endpackage
`default_nettype wire

// ----- hw/rtl/cba_if.sv -----
// cba_req_if and cba_rsp_if: valid/ready channels of the allocator
// no dependencies
`default_nettype none
interface cba_req_if;
   logic         valid;
   logic         ready;
   logic [2:0]   req_type;
   logic [23:0]  byte_count;
   logic         alloc_kind;
   logic [31:0]  owner_id;
   logic [4:0]   handle;
   modport source (output valid, req_type, byte_count, alloc_kind, owner_id, handle,
                   input ready);
   modport sink (input valid, req_type, byte_count, alloc_kind, owner_id, handle,
                 output ready);
endinterface

interface cba_rsp_if;
   logic         valid;
   logic         ready;
   logic [1:0]   status;
   logic [4:0]   out_handle;
   logic [23:0]  block_offset;
   logic [23:0]  block_bytes;
   logic         is_move;
   logic [23:0]  move_from;
   logic [23:0]  move_to;
   logic [21:0]  move_words;
   logic         last;
   modport source (output valid, status, out_handle, block_offset, block_bytes, is_move,
                   move_from, move_to, move_words, last, input ready);
   modport sink (input valid, status, out_handle, block_offset, block_bytes, is_move,
                 move_from, move_to, move_words, last, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/cba_ctrl.sv -----
// cba_ctrl: request sequencer of the allocator
// depends on cba_pkg
`default_nettype none
module cba_ctrl
   import cba_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_fire,
   input  wire logic [2:0]  req_code,
   input  wire logic        rsp_fire,
   input  wire logic        rsp_last,
   input  stat_type         stat,
   output cmd_type          cmd,
   output logic             req_ready,
   output logic             rsp_valid
);
   fsm_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FSM_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         FSM_IDLE: begin
            if (req_fire) begin
               case (req_code)
                  REQ_ALLOC: state_in = FSM_WSTART;
                  REQ_FIT:   state_in = FSM_FIT;
                  REQ_INIT:  state_in = FSM_INIT;
                  default:   state_in = FSM_SIMPLE;
               endcase
            end
         end
         FSM_INIT:   if (stat.init_done) state_in = FSM_RESP;
         FSM_WSTART: state_in = FSM_WALK;
         FSM_WALK: begin
            if (stat.walk_move) state_in = FSM_WMOVE;
            else if (stat.walk_fail) state_in = FSM_RESP;
            else if (stat.walk_found) state_in = stat.need_spare ? FSM_SPARE : FSM_FINISH;
         end
         FSM_WMOVE:  if (rsp_fire) state_in = FSM_WALK;
         FSM_SPARE:  if (stat.spare_done) state_in = stat.spare_found ? FSM_FINISH : FSM_RESP;
         FSM_FINISH: state_in = FSM_RESP;
         FSM_FIT:    if (stat.fit_done) state_in = FSM_RESP;
         FSM_SIMPLE: state_in = FSM_RESP;
         FSM_RESP:   if (rsp_fire && rsp_last) state_in = FSM_IDLE;
         default:    state_in = FSM_IDLE;
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_ready  = 1'b0;
      rsp_valid  = 1'b0;
      case (state_ff)
         FSM_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_fire;
            cmd.init_start = req_fire && req_code == REQ_INIT;
         end
         FSM_INIT:   cmd.init_step = 1'b1;
         FSM_WSTART: cmd.walk_start = 1'b1;
         FSM_WALK: begin
            cmd.walk_step = 1'b1;
            cmd.load_rsp  = stat.walk_fail;
         end
         FSM_WMOVE:  rsp_valid = 1'b1;
         FSM_SPARE: begin
            cmd.spare_step = 1'b1;
            cmd.load_rsp   = stat.spare_done && !stat.spare_found;
         end
         FSM_FINISH: begin
            cmd.finish   = 1'b1;
            cmd.load_rsp = 1'b1;
         end
         FSM_FIT: begin
            cmd.fit_step = 1'b1;
            cmd.load_rsp = stat.fit_done;
         end
         FSM_SIMPLE: begin
            cmd.simple   = 1'b1;
            cmd.load_rsp = 1'b1;
         end
         FSM_RESP:   rsp_valid = 1'b1;
         default:    cmd = '0;
      endcase
      cmd.fit_start = state_ff == FSM_IDLE && req_fire && req_code == REQ_FIT;
   end
endmodule
`default_nettype wire

// ----- hw/rtl/cba_dpath.sv -----
// cba_dpath: handle table, chain walker and result register
// depends on cba_pkg
`default_nettype none
module cba_dpath
   import cba_pkg::*;
#(
   parameter int unsigned NUM_HANDLES = 32
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  cmd_type                    cmd,
   output stat_type                   stat,
   input  wire logic [2:0]            in_req,
   input  wire logic [CNT_W-1:0]      in_count,
   input  wire logic                  in_kind,
   input  wire logic [OWNER_W-1:0]    in_owner,
   input  wire logic [4:0]            in_handle,
   input  wire logic [OFF_W-1:0]      pool_bytes,
   input  wire logic [OFF_W-1:0]      gap_limit,
   output logic [1:0]                 o_status,
   output logic [4:0]                 o_handle,
   output logic [OFF_W-1:0]           o_offset,
   output logic [OFF_W-1:0]           o_bytes,
   output logic                       o_move,
   output logic [OFF_W-1:0]           o_from,
   output logic [OFF_W-1:0]           o_to,
   output logic [WORDS_W-1:0]         o_words,
   output logic                       o_last
);
   localparam int unsigned HW = $clog2(NUM_HANDLES);
   localparam int unsigned LW = HW + 1;          // link with none marker in top bit
   localparam logic [LW-1:0] NONE = {1'b1, {HW{1'b0}}};
   localparam int unsigned WALK_MAX = 4 * NUM_HANDLES;
   localparam int unsigned IW = $clog2(WALK_MAX + 1);

   slot_st_type              st_ff   [NUM_HANDLES];
   logic [OFF_W-1:0]         off_ff  [NUM_HANDLES];
   logic [OFF_W-1:0]         byt_ff  [NUM_HANDLES];
   logic [LW-1:0]            prv_ff  [NUM_HANDLES];
   logic [LW-1:0]            nxt_ff  [NUM_HANDLES];
   logic [OWNER_W-1:0]       own_ff  [NUM_HANDLES];
   logic [LW-1:0]            first_ff;
   logic [LW-1:0]            start_ff;

   logic [2:0]               req_ff;
   logic [OFF_W+1:0]         size_ff;
   logic [OFF_W:0]           need_ff;
   logic                     kind_ff;
   logic [OWNER_W-1:0]       owner_ff;
   logic [4:0]               hdl_ff;
   logic [LW-1:0]            cur_ff;
   logic [IW-1:0]            iter_ff;
   logic [5:0]               moves_ff;
   logic [HW-1:0]            scan_ff;
   logic [LW-1:0]            spare_ff;
   logic [OFF_W+HW:0]        bubble_ff;

   function automatic logic is_none(input logic [LW-1:0] v);
      return v >= LW'(NUM_HANDLES);
   endfunction

   // walk decode, current slot and its successor
   logic [HW-1:0] ci, ni;
   logic [LW-1:0] c_nxt, n_nxt;
   slot_st_type   c_st, n_st;
   logic          c_ok, n_ok, w_found, w_fail, w_merge, w_move;
   always_comb begin
      ci    = cur_ff[HW-1:0];
      c_ok  = !is_none(cur_ff) && iter_ff < IW'(WALK_MAX);
      c_st  = st_ff[ci];
      c_nxt = nxt_ff[ci];
      ni    = c_nxt[HW-1:0];
      n_ok  = !is_none(c_nxt);
      n_st  = st_ff[ni];
      n_nxt = nxt_ff[ni];
      w_found = 1'b0; w_fail = 1'b0; w_merge = 1'b0; w_move = 1'b0;
      if (!c_ok) w_fail = 1'b1;
      else if (c_st == ST_FREE) begin
         if ({2'b0, byt_ff[ci]} >= size_ff) w_found = 1'b1;
         else if (!n_ok) w_fail = 1'b1;
         else if (n_st == ST_FREE) w_merge = 1'b1;
         else if (n_st == ST_FLOAT) begin
            if (moves_ff >= 6'(MAX_MOVES)) w_fail = 1'b1;
            else w_move = 1'b1;
         end
      end
   end

   // fit walk decode
   logic          f_ok;
   logic [OFF_W+HW:0] f_bub;
   always_comb begin
      f_ok  = !is_none(cur_ff) && iter_ff <= IW'(NUM_HANDLES);
      f_bub = bubble_ff;
      if (c_st == ST_FREE && (n_ok || byt_ff[ci] > gap_limit))
         f_bub = bubble_ff + (OFF_W+HW+1)'(byt_ff[ci]);
   end

   logic [HW-1:0] nb;
   assign nb = cur_ff[HW-1:0];

   // table index of the addressed handle
   logic [HW-1:0] hi;
   assign hi = HW'(hdl_ff);

   always_comb begin
      stat = '0;
      stat.init_done   = scan_ff == HW'(NUM_HANDLES - 1);
      stat.walk_found  = w_found;
      stat.walk_fail   = w_fail;
      stat.walk_move   = w_move;
      stat.need_spare  = {2'b0, byt_ff[ci]} != size_ff && !(n_ok && n_st == ST_FREE);
      stat.spare_found = st_ff[scan_ff] == ST_NULL;
      stat.spare_done  = st_ff[scan_ff] == ST_NULL || scan_ff == HW'(NUM_HANDLES - 1);
      stat.fit_done    = !f_ok || (c_st == ST_FREE && f_bub >= (OFF_W+HW+1)'(need_ff));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_ff <= '0;
      end else if (cmd.init_start || cmd.walk_start) begin
         scan_ff <= '0;
      end else if ((cmd.init_step && !stat.init_done) ||
                   (cmd.spare_step && !stat.spare_done)) begin
         scan_ff <= scan_ff + 1'b1;
      end else if (cmd.walk_step && w_found) begin
         scan_ff <= '0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff   <= in_req;
         size_ff  <= ({2'b0, in_count} + 26'd3) & ~26'd3;
         need_ff  <= {1'b0, in_count};
         kind_ff  <= in_kind;
         owner_ff <= in_owner;
         hdl_ff   <= in_handle;
      end
   end

   // handle table
   always_ff @(posedge clock) begin
      if (reset || cmd.init_step) begin
         if (reset) begin
            for (int j = 0; j < NUM_HANDLES; j++) begin
               st_ff[j]  <= (j == 0) ? ST_FREE : ST_NULL;
               off_ff[j] <= '0;
               byt_ff[j] <= (j == 0) ? pool_bytes : '0;
               prv_ff[j] <= NONE;
               nxt_ff[j] <= NONE;
               own_ff[j] <= '0;
            end
         end else begin
            st_ff[scan_ff]  <= (scan_ff == '0) ? ST_FREE : ST_NULL;
            off_ff[scan_ff] <= '0;
            byt_ff[scan_ff] <= (scan_ff == '0) ? pool_bytes : '0;
            prv_ff[scan_ff] <= NONE;
            nxt_ff[scan_ff] <= NONE;
            own_ff[scan_ff] <= '0;
         end
         first_ff <= '0;
         start_ff <= '0;
      end else begin
         if (cmd.simple && 32'(hdl_ff) < NUM_HANDLES && st_ff[hi] != ST_NULL) begin
            case (req_ff)
               REQ_FREE: begin
                  st_ff[hi]  <= ST_FREE;
                  own_ff[hi] <= '0;
               end
               REQ_FLOAT: st_ff[hi] <= ST_FLOAT;
               REQ_LOCK:  st_ff[hi] <= ST_LOCKED;
               default:   st_ff[hi] <= st_ff[hi];
            endcase
         end
         if (cmd.walk_start) spare_ff <= NONE;
         if (cmd.walk_step && w_merge) begin
            byt_ff[ci] <= byt_ff[ci] + byt_ff[ni];
            nxt_ff[ci] <= n_nxt;
            if (!is_none(n_nxt)) prv_ff[n_nxt[HW-1:0]] <= cur_ff;
            st_ff[ni]  <= ST_NULL;
            prv_ff[ni] <= NONE;
            nxt_ff[ni] <= NONE;
            own_ff[ni] <= '0;
         end
         if (cmd.walk_step && w_move) begin
            off_ff[ni] <= off_ff[ci];
            off_ff[ci] <= off_ff[ci] + byt_ff[ni];
            prv_ff[ci] <= c_nxt;
            nxt_ff[ci] <= n_nxt;
            nxt_ff[ni] <= cur_ff;
            prv_ff[ni] <= prv_ff[ci];
            if (!is_none(n_nxt)) prv_ff[n_nxt[HW-1:0]] <= cur_ff;
            if (is_none(prv_ff[ci])) first_ff <= c_nxt;
            else nxt_ff[prv_ff[ci][HW-1:0]] <= c_nxt;
         end
         if (cmd.spare_step && stat.spare_found) begin
            spare_ff <= {1'b0, scan_ff};
            st_ff[scan_ff]  <= ST_FREE;
            own_ff[scan_ff] <= '0;
            byt_ff[scan_ff] <= byt_ff[nb] - size_ff[OFF_W-1:0];
            off_ff[scan_ff] <= off_ff[nb] + size_ff[OFF_W-1:0];
            prv_ff[scan_ff] <= cur_ff;
            nxt_ff[scan_ff] <= c_nxt;
            if (n_ok) prv_ff[ni] <= {1'b0, scan_ff};
            nxt_ff[nb] <= {1'b0, scan_ff};
         end
         if (cmd.finish) begin
            // a freshly split spare already holds the slack
            if ({2'b0, byt_ff[nb]} != size_ff && n_ok && n_st == ST_FREE
                && is_none(spare_ff)) begin
               off_ff[ni] <= off_ff[nb] + size_ff[OFF_W-1:0];
               byt_ff[ni] <= byt_ff[ni] + (byt_ff[nb] - size_ff[OFF_W-1:0]);
            end
            st_ff[nb]  <= kind_ff ? ST_FLOAT : ST_LOCKED;
            byt_ff[nb] <= size_ff[OFF_W-1:0];
            own_ff[nb] <= owner_ff;
         end
         if (cmd.fit_start) start_ff <= first_ff;
         if (cmd.fit_step && f_ok && c_st == ST_LOCKED) start_ff <= c_nxt;
      end
   end

   // walk cursor
   always_ff @(posedge clock) begin
      if (cmd.walk_start) begin
         if (!is_none(start_ff) && st_ff[start_ff[HW-1:0]] == ST_NULL) cur_ff <= first_ff;
         else cur_ff <= start_ff;
         iter_ff  <= '0;
         moves_ff <= '0;
      end else if (cmd.fit_start) begin
         cur_ff    <= first_ff;
         iter_ff   <= '0;
         bubble_ff <= '0;
      end else if (cmd.walk_step && !w_found && !w_fail) begin
         iter_ff <= iter_ff + 1'b1;
         if (c_st != ST_FREE || !(n_st == ST_FREE || n_st == ST_FLOAT)) cur_ff <= c_nxt;
         if (w_move) moves_ff <= moves_ff + 1'b1;
      end else if (cmd.fit_step && !stat.fit_done) begin
         iter_ff <= iter_ff + 1'b1;
         cur_ff  <= c_nxt;
         if (c_st == ST_LOCKED) bubble_ff <= '0;
         else bubble_ff <= f_bub;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         o_last <= 1'b0;
      end else if (cmd.walk_step && w_move) begin
         o_status <= STS_OK;
         o_handle <= 5'(ni);
         o_offset <= '0;
         o_bytes  <= '0;
         o_move   <= 1'b1;
         o_from   <= off_ff[ni];
         o_to     <= off_ff[ci];
         o_words  <= WORDS_W'(byt_ff[ni] >> 2);
         o_last   <= 1'b0;
      end else if (cmd.load_rsp) begin
         o_handle <= '0;
         o_offset <= '0;
         o_bytes  <= '0;
         o_move   <= 1'b0;
         o_from   <= '0;
         o_to     <= '0;
         o_words  <= '0;
         o_last   <= 1'b1;
         if (cmd.walk_step) o_status <= STS_NOSPACE;
         else if (cmd.spare_step) o_status <= STS_NOHANDLE;
         else if (cmd.fit_step) o_status <= (f_ok && c_st == ST_FREE
            && f_bub >= (OFF_W+HW+1)'(need_ff)) ? STS_OK : STS_NOFIT;
         else if (cmd.finish) begin
            o_status <= STS_OK;
            o_handle <= 5'(nb);
            o_offset <= off_ff[nb];
            o_bytes  <= size_ff[OFF_W-1:0];
         end else begin
            o_status <= STS_OK;
            o_handle <= (req_ff == REQ_FREE || req_ff == REQ_FLOAT || req_ff == REQ_LOCK)
                        ? hdl_ff : 5'd0;
         end
      end else if (cmd.init_step && stat.init_done) begin
         o_status <= STS_OK; o_handle <= '0; o_offset <= '0; o_bytes <= '0;
         o_move <= 1'b0; o_from <= '0; o_to <= '0; o_words <= '0; o_last <= 1'b1;
      end
   end
endmodule
`default_nettype wire

// ----- hw/rtl/compacting_block_allocator_core.sv -----
// compacting block allocator: handle table of pool blocks with merge and slide walk
// one request at a time; free, float and lock: result loaded in the simple state, then
// sent from the response state; fit check: one slot a cycle, up to NUM_HANDLES + 1 slots,
// then the result; allocate: a start state, then one slot or merge a cycle, up to
// 4 * NUM_HANDLES steps, held while each slide's move transaction waits; a split scans
// the table for a spare handle, then a finish step; init sweeps the table
// reset is synchronous, active high, clears the table at once and leaves the block idle
`default_nettype none
module compacting_block_allocator_core
   import cba_pkg::*;
#(
   parameter int unsigned NUM_HANDLES = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   cba_req_if.sink          req,
   cba_rsp_if.source        rsp,
   input  wire logic        csr_write_enable,
   input  wire logic [0:0]  csr_index,
   input  wire logic [23:0] csr_write_data
);
   logic [OFF_W-1:0] pool_bytes_ff, gap_limit_ff;
   cmd_type  cmd;
   stat_type stat;
   logic     req_fire, rsp_fire;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pool_bytes_ff <= 24'd12288000;
         gap_limit_ff  <= 24'd51200;
      end else if (csr_write_enable) begin
         if (csr_index == CSR_POOL) pool_bytes_ff <= csr_write_data;
         else gap_limit_ff <= csr_write_data;
      end
   end

   assign req_fire = req.valid && req.ready;
   assign rsp_fire = rsp.valid && rsp.ready;

   // sequencer
   cba_ctrl u_ctrl (
      .clock, .reset, .req_fire, .req_code(req.req_type), .rsp_fire,
      .rsp_last(rsp.last), .stat, .cmd, .req_ready(req.ready), .rsp_valid(rsp.valid)
   );

   // handle table and walker
   cba_dpath #(.NUM_HANDLES(NUM_HANDLES)) u_dpath (
      .clock, .reset, .cmd, .stat,
      .in_req(req.req_type), .in_count(req.byte_count), .in_kind(req.alloc_kind),
      .in_owner(req.owner_id), .in_handle(req.handle),
      .pool_bytes(pool_bytes_ff), .gap_limit(gap_limit_ff),
      .o_status(rsp.status), .o_handle(rsp.out_handle), .o_offset(rsp.block_offset),
      .o_bytes(rsp.block_bytes), .o_move(rsp.is_move), .o_from(rsp.move_from),
      .o_to(rsp.move_to), .o_words(rsp.move_words), .o_last(rsp.last)
   );

   // no new transaction while a result is pending
   a_excl: assert property (@(posedge clock) disable iff (reset)
      !(req.ready && rsp.valid)) else $error("request taken while result pending");
   // a move descriptor is never the last result
   a_move: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.is_move |-> !rsp.last) else $error("move flagged last");
   // after the last result the block returns to ready
   a_ready: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.ready && rsp.last |=> req.ready) else $error("not ready");
endmodule
`default_nettype wire
